>>> rtl/cadence_spike_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cadence spike filter.
// ----------------------------------------------------------------------------
`ifndef CADENCE_SPIKE_FILTER_ASSERT_SVH
`define CADENCE_SPIKE_FILTER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define CSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cadence spike filter: next-cycle check failed");

// The condition must hold at every clock edge outside reset.
`define CSF_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("cadence spike filter: invariant check failed");

`endif

>>> rtl/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// Shared constants and types of the cadence spike filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

   localparam int WindowLen  = 5;
   localparam int MedianRank = WindowLen / 2;
   localparam int SlotW      = $clog2(WindowLen);
   localparam int CountW     = $clog2(WindowLen + 1);
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 16;

   typedef logic [WindowLen-1:0][7:0] csf_window_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_STARTUP_CADENCE  = 3'd0,
      CSR_STARTUP_JUMP_PCT = 3'd1,
      CSR_SPINUP_CADENCE   = 3'd2,
      CSR_SPINUP_JUMP_PCT  = 3'd3,
      CSR_LOW_POWER_WATTS  = 3'd4,
      CSR_STRICT_JUMP_PCT  = 3'd5,
      CSR_STEADY_JUMP_PCT  = 3'd6
   } csf_csr_index_type;

   typedef struct packed {
      logic [7:0]  startup_cadence;
      logic [7:0]  startup_jump_pct;
      logic [7:0]  spinup_cadence;
      logic [7:0]  spinup_jump_pct;
      logic [15:0] low_power_watts;
      logic [7:0]  strict_jump_pct;
      logic [7:0]  steady_jump_pct;
   } csf_cfg_type;

   localparam csf_cfg_type CfgReset = '{
      startup_cadence:  8'd30,
      startup_jump_pct: 8'd200,
      spinup_cadence:   8'd60,
      spinup_jump_pct:  8'd100,
      low_power_watts:  16'd120,
      strict_jump_pct:  8'd15,
      steady_jump_pct:  8'd40
   };

endpackage

`default_nettype wire

>>> rtl/csf_median.sv
// ----------------------------------------------------------------------------
// csf_median
// Median of the sample window by parallel rank counting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csf_median
   import csf_pkg::*;
(
   input  wire csf_window_type samples,
   output logic [7:0]          median
);

   localparam logic [CountW-1:0] Rank = CountW'(MedianRank);

   logic [CountW-1:0]    lt_cnt [WindowLen];
   logic [CountW-1:0]    le_cnt [WindowLen];
   logic [WindowLen-1:0] hit;

   // An entry is the median when fewer than Rank+1 entries lie below it
   // and more than Rank entries lie at or below it. All such entries
   // share one value, so an OR of the hits picks it.
   always_comb begin
      for (int i = 0; i < WindowLen; i++) begin
         lt_cnt[i] = '0;
         le_cnt[i] = '0;
         for (int j = 0; j < WindowLen; j++) begin
            lt_cnt[i] = lt_cnt[i] + CountW'(samples[j] <  samples[i]);
            le_cnt[i] = le_cnt[i] + CountW'(samples[j] <= samples[i]);
         end
         hit[i] = (lt_cnt[i] <= Rank) && (le_cnt[i] > Rank);
      end
   end

   always_comb begin
      median = '0;
      for (int i = 0; i < WindowLen; i++) begin
         median = median | ({8{hit[i]}} & samples[i]);
      end
   end

endmodule

`default_nettype wire

>>> rtl/csf_jump.sv
// ----------------------------------------------------------------------------
// csf_jump
// Decides whether the median jumps too far from the last valid cadence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csf_jump
   import csf_pkg::*;
(
   input  wire csf_cfg_type cfg,
   input  wire [7:0]        last_cadence,
   input  wire [15:0]       power,
   input  wire [7:0]        median,
   output logic             reject
);

   logic [7:0]  pct;
   logic [15:0] allowed;
   logic [7:0]  diff;
   logic [15:0] diff_x100;

   always_comb begin
      if (last_cadence < cfg.startup_cadence) begin
         pct = cfg.startup_jump_pct;
      end else if (last_cadence < cfg.spinup_cadence) begin
         pct = cfg.spinup_jump_pct;
      end else if (power < cfg.low_power_watts) begin
         pct = cfg.strict_jump_pct;
      end else begin
         pct = cfg.steady_jump_pct;
      end
   end

   // The window is last +/- floor(last * pct / 100). For an integer
   // distance d, d > floor(x / 100) holds exactly when 100 * d > x, so
   // the bound needs no divider. The median never exceeds 255, which
   // makes the saturated upper bound the same test.
   assign allowed   = 16'(last_cadence) * 16'(pct);
   assign diff      = (median >= last_cadence) ? (median - last_cadence)
                                               : (last_cadence - median);
   assign diff_x100 = 16'({diff, 6'b0}) + 16'({diff, 5'b0}) + 16'({diff, 2'b0});
   assign reject    = (last_cadence != 8'd0) && (diff_x100 > allowed);

endmodule

`default_nettype wire

>>> rtl/cadence_spike_filter.sv
// ----------------------------------------------------------------------------
// cadence_spike_filter
// Median-of-window cadence filter with adaptive jump rejection.
// ----------------------------------------------------------------------------
// Each req beat carries one raw cadence sample and the instant power; each
// produces exactly one rsp beat with the filtered cadence and a held flag.
// A req beat lands in an input register; combinational logic (window
// update, rank-count median, one 8x8 multiply for the jump bound) moves it
// into the rsp register, which drives rsp_valid. One beat per cycle is
// sustained while rsp_ready stays high; the single compute stage, whose
// result also updates the window and the last valid cadence, sets that rate.
// When rsp_ready is low the rsp register holds its beat and the input
// register still takes one more beat; req_ready falls only when both hold
// data. Zero power answers 0 and forgets the last cadence, leaving the
// window alone. Synchronous reset empties both stages, zeroes the window,
// the write slot and the last cadence, and loads the default thresholds.
// csr_we writes one register per cycle with no wait; write only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cadence_spike_filter_assert.svh"

module cadence_spike_filter
   import csf_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire [7:0]           req_raw_cadence,
   input  wire [15:0]          req_power,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [7:0]          rsp_cadence,
   output logic                rsp_held,
   input  wire                 csr_we,
   input  wire [CsrIdxW-1:0]   csr_index,
   input  wire [CsrDataW-1:0]  csr_wdata
);

   localparam logic [SlotW-1:0] SlotLast = SlotW'(WindowLen - 1);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     raw_ff;
   logic [15:0]    power_ff;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     cadence_ff, cadence_in;
   logic           held_ff, held_in;
   csf_window_type window_ff, window_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [7:0]     last_ff, last_in;
   csf_cfg_type    cfg_ff, cfg_in;

   csf_window_type win_wr;
   logic [7:0]     median;
   logic           reject;
   logic           advance;
   logic           stopped;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign stopped   = (power_ff == 16'd0);

   always_comb begin
      for (int i = 0; i < WindowLen; i++) begin
         win_wr[i] = (slot_ff == SlotW'(i)) ? raw_ff : window_ff[i];
      end
   end

   csf_median u_median (
      .samples (win_wr),
      .median  (median)
   );

   csf_jump u_jump (
      .cfg          (cfg_ff),
      .last_cadence (last_ff),
      .power        (power_ff),
      .median       (median),
      .reject       (reject)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      cadence_in   = cadence_ff;
      held_in      = held_ff;
      window_in    = window_ff;
      slot_in      = slot_ff;
      last_in      = last_ff;
      cfg_in       = cfg_ff;

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         if (stopped) begin
            cadence_in = 8'd0;
            held_in    = 1'b0;
            last_in    = 8'd0;
         end else begin
            cadence_in = reject ? last_ff : median;
            held_in    = reject;
            last_in    = reject ? last_ff : median;
            window_in  = win_wr;
            slot_in    = (slot_ff == SlotLast) ? '0 : slot_ff + 1'b1;
         end
      end

      if (csr_we) begin
         case (csr_index)
            CSR_STARTUP_CADENCE:  cfg_in.startup_cadence  = csr_wdata[7:0];
            CSR_STARTUP_JUMP_PCT: cfg_in.startup_jump_pct = csr_wdata[7:0];
            CSR_SPINUP_CADENCE:   cfg_in.spinup_cadence   = csr_wdata[7:0];
            CSR_SPINUP_JUMP_PCT:  cfg_in.spinup_jump_pct  = csr_wdata[7:0];
            CSR_LOW_POWER_WATTS:  cfg_in.low_power_watts  = csr_wdata;
            CSR_STRICT_JUMP_PCT:  cfg_in.strict_jump_pct  = csr_wdata[7:0];
            CSR_STEADY_JUMP_PCT:  cfg_in.steady_jump_pct  = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         window_ff    <= '0;
         slot_ff      <= '0;
         last_ff      <= 8'd0;
         cfg_ff       <= CfgReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         window_ff    <= window_in;
         slot_ff      <= slot_in;
         last_ff      <= last_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         raw_ff   <= req_raw_cadence;
         power_ff <= req_power;
      end
      cadence_ff <= cadence_in;
      held_ff    <= held_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_cadence = cadence_ff;
   assign rsp_held    = held_ff;

   `CSF_ASSERT_ALWAYS(a_slot_in_range, clock, reset, slot_ff <= SlotLast)
   `CSF_ASSERT_NEXT(a_stop_clears, clock, reset, advance && stopped,
      (last_ff == 8'd0) && (rsp_cadence == 8'd0) && !rsp_held)
   `CSF_ASSERT_NEXT(a_held_keeps_last, clock, reset, advance && !stopped && reject,
      (last_ff == $past(last_ff)) && (rsp_cadence == $past(last_ff)))
   `CSF_ASSERT_NEXT(a_no_hold_from_zero, clock, reset, advance && (last_ff == 8'd0),
      !rsp_held)

endmodule

`default_nettype wire

>>> test/cadence_spike_filter_tb.sv
// ----------------------------------------------------------------------------
// cadence_spike_filter_tb
// Self-checking bench for the cadence spike filter.
// ----------------------------------------------------------------------------
// Samples are queued by the stimulus process and sent by a clocked driver.
// Every accepted sample runs through a local copy of the filter: the ring,
// the median, the jump window and the held flag. The expected cadence goes
// into a queue, and a clocked monitor compares each response beat against it.
// The thresholds are reloaded between phases while the block is idle, and the
// extremes are covered. Both handshakes stall at random, except in one
// phase that runs at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cadence_spike_filter_tb
   import csf_pkg::*;
();

   typedef struct packed {
      logic [7:0]  raw;
      logic [15:0] power;
   } sample_type;

   typedef struct packed {
      logic [7:0] cadence;
      logic       held;
   } filtered_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_raw_cadence = '0;
   logic [15:0]         req_power = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [7:0]          rsp_cadence;
   logic                rsp_held;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   sample_type   sample_queue[$];
   filtered_type cadence_due[$];
   int           errors = 0;
   logic         calm = 1'b0;
   int           ride_rpm = 0;

   // Local copy of the filter state and thresholds.
   csf_cfg_type thresholds;
   logic [7:0]  ring [WindowLen];
   int          ring_slot;
   logic [7:0]  last_cadence;

   cadence_spike_filter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_raw_cadence (req_raw_cadence),
      .req_power       (req_power),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cadence     (rsp_cadence),
      .rsp_held        (rsp_held),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] ring_median();
      logic [7:0] s [WindowLen];
      logic [7:0] v;
      int         i, j;
      for (i = 0; i < WindowLen; i++) s[i] = ring[i];
      for (i = 1; i < WindowLen; i++) begin
         v = s[i];
         j = i - 1;
         while (j >= 0 && s[j] > v) begin
            s[j + 1] = s[j];
            j--;
         end
         s[j + 1] = v;
      end
      return s[MedianRank];
   endfunction

   function automatic int unsigned jump_percent(logic [7:0] last, logic [15:0] pw);
      if (last < thresholds.startup_cadence) return thresholds.startup_jump_pct;
      if (last < thresholds.spinup_cadence) return thresholds.spinup_jump_pct;
      if (pw < thresholds.low_power_watts) return thresholds.strict_jump_pct;
      return thresholds.steady_jump_pct;
   endfunction

   function automatic void filter_sample(logic [7:0] raw, logic [15:0] pw);
      filtered_type res;
      int unsigned  jump, hi, lo;
      res = '0;
      if (pw == 0) begin
         last_cadence = '0;
      end else begin
         ring[ring_slot] = raw;
         ring_slot = (ring_slot + 1) % WindowLen;
         res.cadence = ring_median();
         if (last_cadence != 0) begin
            jump = (last_cadence * jump_percent(last_cadence, pw)) / 100;
            hi = last_cadence + jump;
            lo = (last_cadence > jump) ? last_cadence - jump : 0;
            if (hi > 255) hi = 255;
            if (res.cadence > hi || res.cadence < lo) begin
               res.cadence = last_cadence;
               res.held = 1'b1;
            end
         end
         last_cadence = res.cadence;
      end
      cadence_due.push_back(res);
   endfunction

   // A beat that is not taken keeps valid high with the same payload.
   always @(posedge clock) begin : drive_samples
      sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) filter_sample(req_raw_cadence, req_power);
         if (!req_valid || req_ready) begin
            if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
               nxt = sample_queue.pop_front();
               req_valid       <= 1'b1;
               req_raw_cadence <= nxt.raw;
               req_power       <= nxt.power;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_cadence
      filtered_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cadence_due.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual cadence %0d held %0d",
                        $time, rsp_cadence, rsp_held);
               errors++;
            end else begin
               want = cadence_due.pop_front();
               if (rsp_cadence !== want.cadence) begin
                  $display("%0t: cadence mismatch, expected %0d, actual %0d",
                           $time, want.cadence, rsp_cadence);
                  errors++;
               end
               if (rsp_held !== want.held) begin
                  $display("%0t: held mismatch, expected %0d, actual %0d",
                           $time, want.held, rsp_held);
                  errors++;
               end
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   task automatic csr_write(input csf_csr_index_type idx, input logic [15:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_STARTUP_CADENCE:  thresholds.startup_cadence  = data[7:0];
         CSR_STARTUP_JUMP_PCT: thresholds.startup_jump_pct = data[7:0];
         CSR_SPINUP_CADENCE:   thresholds.spinup_cadence   = data[7:0];
         CSR_SPINUP_JUMP_PCT:  thresholds.spinup_jump_pct  = data[7:0];
         CSR_LOW_POWER_WATTS:  thresholds.low_power_watts  = data;
         CSR_STRICT_JUMP_PCT:  thresholds.strict_jump_pct  = data[7:0];
         CSR_STEADY_JUMP_PCT:  thresholds.steady_jump_pct  = data[7:0];
         default: ;
      endcase
   endtask

   // The 8-bit registers get junk in the upper byte, which must be dropped.
   task automatic load_thresholds(input csf_cfg_type c);
      csr_write(CSR_STARTUP_CADENCE,  {8'($urandom_range(255)), c.startup_cadence});
      csr_write(CSR_STARTUP_JUMP_PCT, {8'($urandom_range(255)), c.startup_jump_pct});
      csr_write(CSR_SPINUP_CADENCE,   {8'($urandom_range(255)), c.spinup_cadence});
      csr_write(CSR_SPINUP_JUMP_PCT,  {8'($urandom_range(255)), c.spinup_jump_pct});
      csr_write(CSR_LOW_POWER_WATTS,  c.low_power_watts);
      csr_write(CSR_STRICT_JUMP_PCT,  {8'($urandom_range(255)), c.strict_jump_pct});
      csr_write(CSR_STEADY_JUMP_PCT,  {8'($urandom_range(255)), c.steady_jump_pct});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly a plausible ride: cadence drifting slowly with sensor jitter,
   // some spikes, stops that restart from a low cadence, and mixed power.
   task automatic queue_ride(input int n);
      int         k, r, v;
      sample_type s;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 4) begin
            s.power = '0;
            ride_rpm = $urandom_range(40);
         end else if (r < 30) begin
            s.power = 16'($urandom_range(200, 1));
         end else if (r < 34) begin
            s.power = r[0] ? 16'hFFFF : 16'd1;
         end else begin
            s.power = 16'($urandom_range(65535));
         end
         if ($urandom_range(99) < 3) ride_rpm = $urandom_range(255);
         else ride_rpm = ride_rpm + int'($urandom_range(7)) - 3;
         if (ride_rpm < 0) ride_rpm = 0;
         if (ride_rpm > 255) ride_rpm = 255;
         if ($urandom_range(99) < 8) begin
            s.raw = 8'($urandom_range(255));
         end else begin
            v = ride_rpm + int'($urandom_range(8)) - 4;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            s.raw = 8'(v);
         end
         sample_queue.push_back(s);
      end
   endtask

   // The falling edge sees the queues and the request after the clocked
   // driver and monitor have settled.
   task automatic wait_idle();
      int guard;
      guard = 0;
      while ((sample_queue.size() != 0 || req_valid || cadence_due.size() != 0)
             && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      if (guard >= 20000) begin
         $display("%0t: results still missing, expected %0d more, actual none",
                  $time, cadence_due.size());
         errors++;
         cadence_due.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic csf_cfg_type random_thresholds();
      csf_cfg_type c;
      c.startup_cadence  = 8'($urandom_range(255));
      c.startup_jump_pct = 8'($urandom_range(255));
      c.spinup_cadence   = 8'($urandom_range(255));
      c.spinup_jump_pct  = 8'($urandom_range(255));
      c.low_power_watts  = 16'($urandom_range(65535));
      c.strict_jump_pct  = 8'($urandom_range(255));
      c.steady_jump_pct  = 8'($urandom_range(255));
      return c;
   endfunction

   initial begin : stimulus
      int          ph;
      csf_cfg_type c;
      thresholds   = CfgReset;
      for (ph = 0; ph < WindowLen; ph++) ring[ph] = '0;
      ring_slot    = 0;
      last_cadence = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Default thresholds: a stop with nothing before it, the empty ring,
      // extreme fields, a spike held off, saturation at the top and a lower
      // bound that falls to zero in the startup zone.
      sample_queue.push_back('{8'd77, 16'd0});
      sample_queue.push_back('{8'd0, 16'd1});
      sample_queue.push_back('{8'd255, 16'hFFFF});
      sample_queue.push_back('{8'd90, 16'd200});
      sample_queue.push_back('{8'd90, 16'd200});
      sample_queue.push_back('{8'd95, 16'd300});
      repeat (3) sample_queue.push_back('{8'd250, 16'd300});
      sample_queue.push_back('{8'd250, 16'd50});
      sample_queue.push_back('{8'd0, 16'd0});
      repeat (3) sample_queue.push_back('{8'd240, 16'd300});
      repeat (3) sample_queue.push_back('{8'd255, 16'd300});
      sample_queue.push_back('{8'd10, 16'd0});
      repeat (5) sample_queue.push_back('{8'd10, 16'd1});
      sample_queue.push_back('{8'd0, 16'd0});
      sample_queue.push_back('{8'd10, 16'd5});
      repeat (2) sample_queue.push_back('{8'd0, 16'd5});
      queue_ride(210);
      wait_idle();

      for (ph = 1; ph < 8; ph++) begin
         c = random_thresholds();
         case (ph)
            2: c = '0;
            3: c = '1;
            5: begin
               c.startup_cadence = 8'd0;
               c.spinup_cadence  = 8'd255;
            end
            6: c.low_power_watts = 16'd0;
            7: c = CfgReset;
            default: ;
         endcase
         load_thresholds(c);
         calm = (ph == 4);
         queue_ride(210);
         wait_idle();
      end

      if (errors == 0) begin
         $display("[cadence_spike_filter] OK");
      end else begin
         $display("[cadence_spike_filter] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("[cadence_spike_filter] ERROR");
      $finish;
   end

endmodule
